/* hw/rtl/cdudc_pkg.sv */
// Package for the calendar date up/down counter.
// Holds field widths, year limits, the function codes and the month-length table.
// Depends on nothing; used by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package cdudc_pkg;

   localparam int unsigned DayW   = 5;
   localparam int unsigned LdDayW = 6;
   localparam int unsigned MonthW = 4;
   localparam int unsigned YearW  = 14;
   localparam int unsigned FuncW  = 2;

   localparam int unsigned ReqDataW = 24;
   localparam int unsigned RspDataW = 32;

   localparam logic [YearW-1:0]  DefaultYear = YearW'(2019);
   localparam logic [YearW-1:0]  MinYear     = YearW'(1000);
   localparam logic [YearW-1:0]  MaxYear     = YearW'(9999);
   localparam logic [MonthW-1:0] FirstMonth  = MonthW'(1);
   localparam logic [MonthW-1:0] LastMonth   = MonthW'(12);
   localparam logic [DayW-1:0]   FirstDay    = DayW'(1);

   typedef enum logic [FuncW-1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_FWD  = 2'd1,
      FUNC_BACK = 2'd2
   } func_type;

   // Days in a month; the leap table differs only in February.
   // A month code outside 1..12 is treated as January.
   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                 input logic leap);
      logic [DayW-1:0] len;
      begin
         case (month)
            4'd2:    len = leap ? DayW'(29) : DayW'(28);
            4'd4:    len = DayW'(30);
            4'd6:    len = DayW'(30);
            4'd9:    len = DayW'(30);
            4'd11:   len = DayW'(30);
            default: len = DayW'(31);
         endcase
         month_len = len;
      end
   endfunction

   // A year counts as leap when it divides by four, with no century rule.
   function automatic logic year_leap(input logic [YearW-1:0] year);
      year_leap = (year[1:0] == 2'b00);
   endfunction

endpackage

/* hw/rtl/calendar_date_up_down_counter.sv */
// Top level of the calendar date up/down counter.
// Holds the date state, an input stage and a result register.
// Depends on cdudc_pkg.
`timescale 1ns / 1ps

// Usage
// The request channel (req_*) carries one command per transfer. req_tuser selects
// the function: load a date, step one day forward or step one day back. For a
// load, req_tdata carries the day, month and year to load; a load checks each
// field and replaces an invalid year by 2019, an invalid month by 1 and a day
// outside the month's length by 1. Unused function code 3 leaves the date as it is.
// Every request transfer produces exactly one response transfer on rsp_*, with the
// date after the command, the leap flag and the three correction flags.
// A command passes through the input stage and then the result register before
// rsp_tvalid rises. Throughput is one command per cycle while the receiver keeps
// rsp_tready high; the date update is a single pass of compare, increment and
// month-length table lookup between the input stage and the date registers.
// When the receiver holds rsp_tready low, the response holds and the input stage
// fills; req_tready falls only once both stages hold a command.
// Synchronous reset sets the date to January 1, 2019, clears the leap flag and
// empties both stages.

module calendar_date_up_down_counter (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [5:0] load_day, [9:6] load_month, [23:10] load_year.
   input  logic [cdudc_pkg::ReqDataW-1:0] req_tdata,
   // [1:0] func.
   input  logic [cdudc_pkg::FuncW-1:0]    req_tuser,
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [4:0] cur_day, [8:5] cur_month, [22:9] cur_year, [23] leap_flag,
   // [24] year_fixed, [25] month_fixed, [26] day_fixed, [31:27] zero.
   output logic [cdudc_pkg::RspDataW-1:0] rsp_tdata
);

   localparam int unsigned DayW   = cdudc_pkg::DayW;
   localparam int unsigned MonthW = cdudc_pkg::MonthW;
   localparam int unsigned YearW  = cdudc_pkg::YearW;
   localparam int unsigned LdDayW = cdudc_pkg::LdDayW;

   // Input stage.
   logic                               s1_vld_ff, s1_vld_in;
   logic [cdudc_pkg::FuncW-1:0]        s1_func_ff;
   logic [cdudc_pkg::ReqDataW-1:0]     s1_data_ff;

   // Date state.
   logic [DayW-1:0]   day_ff, day_in;
   logic [MonthW-1:0] month_ff, month_in;
   logic [YearW-1:0]  year_ff, year_in;
   logic              leap_ff, leap_in;

   // Result register.
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [cdudc_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic advance;

   // Fields of the staged load.
   logic [LdDayW-1:0] ld_day;
   logic [MonthW-1:0] ld_month;
   logic [YearW-1:0]  ld_year;

   logic yfix, mfix, dfix;

   // The result register can take a new value when it is empty or being drained.
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign ld_day   = s1_data_ff[LdDayW-1:0];
   assign ld_month = s1_data_ff[LdDayW +: MonthW];
   assign ld_year  = s1_data_ff[LdDayW+MonthW +: YearW];

   always_comb begin
      logic              ly_ok;
      logic              lm_ok;
      logic [DayW-1:0]   len_cur;
      logic [DayW-1:0]   len_prev;
      logic [DayW-1:0]   len_ld;
      logic [MonthW-1:0] prev_month;
      logic [YearW-1:0]  prev_year;
      logic              prev_leap;

      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      leap_in  = leap_ff;
      yfix     = 1'b0;
      mfix     = 1'b0;
      dfix     = 1'b0;

      ly_ok   = (ld_year >= cdudc_pkg::MinYear) && (ld_year <= cdudc_pkg::MaxYear);
      lm_ok   = (ld_month >= cdudc_pkg::FirstMonth) && (ld_month <= cdudc_pkg::LastMonth);
      len_cur = cdudc_pkg::month_len(month_ff, leap_ff);

      // Month and year that a backward step across a month boundary lands in.
      if (month_ff <= cdudc_pkg::FirstMonth) begin
         prev_month = cdudc_pkg::LastMonth;
         prev_year  = (year_ff <= cdudc_pkg::MinYear) ? cdudc_pkg::MaxYear
                                                       : year_ff - YearW'(1);
         prev_leap  = cdudc_pkg::year_leap(prev_year);
      end else begin
         prev_month = month_ff - MonthW'(1);
         prev_year  = year_ff;
         prev_leap  = leap_ff;
      end
      len_prev = cdudc_pkg::month_len(prev_month, prev_leap);

      // Load path: year first, then month, then the day against the corrected month.
      if (!ly_ok) begin
         yfix = 1'b1;
      end
      if (!lm_ok) begin
         mfix = 1'b1;
      end
      len_ld = cdudc_pkg::month_len(lm_ok ? ld_month : cdudc_pkg::FirstMonth,
                                    cdudc_pkg::year_leap(ly_ok ? ld_year
                                                               : cdudc_pkg::DefaultYear));

      if (s1_vld_ff && advance) begin
         case (s1_func_ff)
            cdudc_pkg::FUNC_LOAD: begin
               year_in  = ly_ok ? ld_year : cdudc_pkg::DefaultYear;
               month_in = lm_ok ? ld_month : cdudc_pkg::FirstMonth;
               leap_in  = cdudc_pkg::year_leap(year_in);
               if ((ld_day != '0) && (ld_day <= LdDayW'(len_ld))) begin
                  day_in = ld_day[DayW-1:0];
               end else begin
                  day_in = cdudc_pkg::FirstDay;
                  dfix   = 1'b1;
               end
            end
            cdudc_pkg::FUNC_FWD: begin
               if (day_ff >= len_cur) begin
                  day_in = cdudc_pkg::FirstDay;
                  if (month_ff >= cdudc_pkg::LastMonth) begin
                     month_in = cdudc_pkg::FirstMonth;
                     year_in  = (year_ff >= cdudc_pkg::MaxYear) ? cdudc_pkg::MinYear
                                                                 : year_ff + YearW'(1);
                     leap_in  = cdudc_pkg::year_leap(year_in);
                  end else begin
                     month_in = month_ff + MonthW'(1);
                  end
               end else begin
                  day_in = day_ff + DayW'(1);
               end
            end
            cdudc_pkg::FUNC_BACK: begin
               if (day_ff <= cdudc_pkg::FirstDay) begin
                  month_in = prev_month;
                  year_in  = prev_year;
                  leap_in  = prev_leap;
                  day_in   = len_prev;
               end else begin
                  day_in = day_ff - DayW'(1);
               end
            end
            default: begin
               // Unused code: the date holds.
            end
         endcase
      end

      // Correction flags are reported for loads only.
      if (s1_func_ff != cdudc_pkg::FUNC_LOAD) begin
         yfix = 1'b0;
         mfix = 1'b0;
         dfix = 1'b0;
      end
   end

   // Stage handshake.
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_xfer) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end

      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_vld_in  = s1_vld_ff;
         rsp_data_in = {5'b0, dfix, mfix, yfix, leap_in, year_in, month_in, day_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         day_ff     <= cdudc_pkg::FirstDay;
         month_ff   <= cdudc_pkg::FirstMonth;
         year_ff    <= cdudc_pkg::DefaultYear;
         leap_ff    <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         leap_ff    <= leap_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_func_ff <= req_tuser;
         s1_data_ff <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/cdudc_checker.sv */
// Port-level checker for the calendar date up/down counter, with its bind.
// Watches the response channel for legal dates and reset behavior.
// Depends on cdudc_pkg and calendar_date_up_down_counter.
`timescale 1ns / 1ps

module cdudc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cdudc_pkg::RspDataW-1:0] rsp_tdata
);

   logic [cdudc_pkg::DayW-1:0]   day;
   logic [cdudc_pkg::MonthW-1:0] month;
   logic [cdudc_pkg::YearW-1:0]  year;
   logic                         leap;

   assign day   = rsp_tdata[4:0];
   assign month = rsp_tdata[8:5];
   assign year  = rsp_tdata[22:9];
   assign leap  = rsp_tdata[23];

   // No response is valid after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The date shown is always a legal calendar date in range.
   a_date_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (year >= cdudc_pkg::MinYear) && (year <= cdudc_pkg::MaxYear) &&
                     (month >= cdudc_pkg::FirstMonth) && (month <= cdudc_pkg::LastMonth) &&
                     (day >= cdudc_pkg::FirstDay) && (day <= cdudc_pkg::month_len(month, leap)))
      else $error("illegal date on response");

   // The leap flag follows the year shown beside it.
   a_leap_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (leap == cdudc_pkg::year_leap(year)))
      else $error("leap flag does not match year");

   // A stalled response holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // With the output draining, the request side is never refused.
   a_no_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request refused while response drains");

endmodule

bind calendar_date_up_down_counter cdudc_checker u_cdudc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/tb_top.sv */
// Self-checking testbench for the calendar date up/down counter.
// Drives load and day-step commands on the request stream, predicts each date and checks
// every response transfer. Depends on cdudc_pkg and calendar_date_up_down_counter.
`timescale 1ns / 1ps

module tb_top;

   // The fourth function code is not in the package enum; the block holds its date on it.
   localparam logic [cdudc_pkg::FuncW-1:0] FUNC_UNUSED = 2'd3;

   localparam int NUM_DIRECTED = 25;
   localparam int NUM_RANDOM   = 1650;
   localparam int HOLD_ITEM    = 300;
   localparam int HOLD_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 250000;

   typedef struct packed {
      logic [cdudc_pkg::FuncW-1:0]  func;
      logic [cdudc_pkg::LdDayW-1:0] day;
      logic [cdudc_pkg::MonthW-1:0] month;
      logic [cdudc_pkg::YearW-1:0]  year;
   } cal_cmd_type;

   typedef struct packed {
      logic [cdudc_pkg::DayW-1:0]   day;
      logic [cdudc_pkg::MonthW-1:0] month;
      logic [cdudc_pkg::YearW-1:0]  year;
      logic                         leap;
      logic                         year_fixed;
      logic                         month_fixed;
      logic                         day_fixed;
   } cal_date_type;

   // One row of the directed table. When has_date is set, the expected date is the one
   // typed in the row; otherwise the calendar predictor supplies it.
   typedef struct packed {
      logic [cdudc_pkg::FuncW-1:0]  func;
      logic [cdudc_pkg::LdDayW-1:0] day;
      logic [cdudc_pkg::MonthW-1:0] month;
      logic [cdudc_pkg::YearW-1:0]  year;
      logic                         has_date;
      cal_date_type                 date;
   } dir_row_type;

   localparam cal_date_type NO_DATE = '0;

   localparam dir_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // The unused code right after reset shows the reset date.
      '{FUNC_UNUSED, 0, 0, 0, 1, '{1, 1, 2019, 0, 0, 0, 0}},
      // Stepping back from January 1 crosses into the previous year.
      '{cdudc_pkg::FUNC_BACK, 0, 0, 0, 1, '{31, 12, 2018, 0, 0, 0, 0}},
      // All-ones and all-zeros loads: every field is replaced.
      '{cdudc_pkg::FUNC_LOAD, 63, 15, 16383, 1, '{1, 1, 2019, 0, 1, 1, 1}},
      '{cdudc_pkg::FUNC_LOAD, 0, 0, 0, 1, '{1, 1, 2019, 0, 1, 1, 1}},
      // Year wrap forward from the last day of 9999, and back again from 1000.
      '{cdudc_pkg::FUNC_LOAD, 31, 12, 9999, 1, '{31, 12, 9999, 0, 0, 0, 0}},
      '{cdudc_pkg::FUNC_FWD, 0, 0, 0, 1, '{1, 1, 1000, 1, 0, 0, 0}},
      '{cdudc_pkg::FUNC_BACK, 0, 0, 0, 1, '{31, 12, 9999, 0, 0, 0, 0}},
      '{cdudc_pkg::FUNC_LOAD, 1, 1, 1000, 1, '{1, 1, 1000, 1, 0, 0, 0}},
      '{cdudc_pkg::FUNC_BACK, 63, 15, 16383, 1, '{31, 12, 9999, 0, 0, 0, 0}},
      // February in a leap year.
      '{cdudc_pkg::FUNC_LOAD, 29, 2, 2020, 0, NO_DATE},
      '{cdudc_pkg::FUNC_FWD, 0, 0, 0, 0, NO_DATE},
      '{cdudc_pkg::FUNC_BACK, 0, 0, 0, 0, NO_DATE},
      // February 29 in a common year is not a valid day.
      '{cdudc_pkg::FUNC_LOAD, 29, 2, 2019, 1, '{1, 2, 2019, 0, 0, 0, 1}},
      '{cdudc_pkg::FUNC_LOAD, 31, 4, 2021, 0, NO_DATE},
      // Years just outside the valid range, and a month past December.
      '{cdudc_pkg::FUNC_LOAD, 30, 4, 999, 0, NO_DATE},
      '{cdudc_pkg::FUNC_LOAD, 28, 2, 10000, 0, NO_DATE},
      '{cdudc_pkg::FUNC_LOAD, 31, 13, 2024, 0, NO_DATE},
      // A century year that divides by four counts as leap here.
      '{cdudc_pkg::FUNC_LOAD, 28, 2, 2100, 0, NO_DATE},
      '{cdudc_pkg::FUNC_FWD, 0, 0, 0, 0, NO_DATE},
      '{FUNC_UNUSED, 63, 15, 16383, 0, NO_DATE},
      '{cdudc_pkg::FUNC_LOAD, 30, 6, 2023, 0, NO_DATE},
      '{cdudc_pkg::FUNC_FWD, 0, 0, 0, 0, NO_DATE},
      '{cdudc_pkg::FUNC_BACK, 0, 0, 0, 0, NO_DATE},
      '{cdudc_pkg::FUNC_LOAD, 1, 3, 2024, 0, NO_DATE},
      '{cdudc_pkg::FUNC_BACK, 0, 0, 0, 0, NO_DATE}
   };

   localparam int NORMAL_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int LEAP_DAYS [12]   = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int EDGE_YEARS [6]   = '{1000, 1001, 2019, 2020, 9998, 9999};
   localparam int EDGE_DAYS [5]    = '{1, 28, 29, 30, 31};

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [cdudc_pkg::ReqDataW-1:0] req_tdata;
   logic [cdudc_pkg::FuncW-1:0]    req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [cdudc_pkg::RspDataW-1:0] rsp_tdata;

   // Calendar predictor state.
   int cal_day;
   int cal_month;
   int cal_year;
   int cal_leap;

   cal_date_type date_q[$];
   int        n_errors;
   int        cycle_count;
   int        burst_left;
   int        run_left;
   logic [cdudc_pkg::FuncW-1:0] run_func;
   int        hold_requests;
   int        hold_served;

   calendar_date_up_down_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int days_in_month(input int month, input int leap);
      int idx;
      idx = (month >= 1 && month <= 12) ? month - 1 : 0;
      return leap ? LEAP_DAYS[idx] : NORMAL_DAYS[idx];
   endfunction

   // Applies one command to the predicted calendar and returns the date it shows.
   task automatic advance_calendar(input cal_cmd_type cmd, output cal_date_type res);
      res = '0;
      if (cmd.func == cdudc_pkg::FUNC_LOAD) begin
         if (cmd.year >= cdudc_pkg::MinYear && cmd.year <= cdudc_pkg::MaxYear) begin
            cal_year = cmd.year;
         end else begin
            cal_year = cdudc_pkg::DefaultYear;
            res.year_fixed = 1'b1;
         end
         if (cmd.month >= 1 && cmd.month <= 12) begin
            cal_month = cmd.month;
         end else begin
            cal_month = 1;
            res.month_fixed = 1'b1;
         end
         cal_leap = (cal_year % 4 == 0);
         // The day is checked against the month as corrected above.
         if (cmd.day >= 1 && cmd.day <= days_in_month(cal_month, cal_leap)) begin
            cal_day = cmd.day;
         end else begin
            cal_day = 1;
            res.day_fixed = 1'b1;
         end
      end else if (cmd.func == cdudc_pkg::FUNC_FWD) begin
         cal_day++;
         if (cal_day > days_in_month(cal_month, cal_leap)) begin
            cal_day = 1;
            cal_month++;
            if (cal_month > 12) begin
               cal_month = 1;
               cal_year++;
               if (cal_year > cdudc_pkg::MaxYear) cal_year = cdudc_pkg::MinYear;
               cal_leap = (cal_year % 4 == 0);
            end
         end
      end else if (cmd.func == cdudc_pkg::FUNC_BACK) begin
         if (cal_day <= 1) begin
            if (cal_month <= 1) begin
               cal_month = 12;
               cal_year = (cal_year <= cdudc_pkg::MinYear) ? int'(cdudc_pkg::MaxYear)
                                                           : cal_year - 1;
               cal_leap = (cal_year % 4 == 0);
            end else begin
               cal_month--;
            end
            cal_day = days_in_month(cal_month, cal_leap);
         end else begin
            cal_day--;
         end
      end
      res.day   = cdudc_pkg::DayW'(cal_day);
      res.month = cdudc_pkg::MonthW'(cal_month);
      res.year  = cdudc_pkg::YearW'(cal_year);
      res.leap  = cal_leap[0];
   endtask

   // Random commands come mostly as runs of day steps in one direction, broken by loads
   // in range, near month and year ends or of raw random bits, and by the unused code.
   function automatic cal_cmd_type next_random_cmd();
      cal_cmd_type cmd;
      int sel;
      int kind;
      cmd.func  = FUNC_UNUSED;
      cmd.day   = cdudc_pkg::LdDayW'($urandom_range(0, 63));
      cmd.month = cdudc_pkg::MonthW'($urandom_range(0, 15));
      cmd.year  = cdudc_pkg::YearW'($urandom_range(0, 16383));
      if (run_left > 0) begin
         run_left--;
         cmd.func = run_func;
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 4) begin
            cmd.func = FUNC_UNUSED;
         end else if (sel < 40) begin
            cmd.func = cdudc_pkg::FUNC_LOAD;
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
               cmd.year  = cdudc_pkg::YearW'($urandom_range(1000, 9999));
               cmd.month = cdudc_pkg::MonthW'($urandom_range(1, 12));
               cmd.day   = cdudc_pkg::LdDayW'($urandom_range(1, 31));
            end else if (kind < 8) begin
               cmd.year = cdudc_pkg::YearW'(EDGE_YEARS[$urandom_range(0, 5)]);
               case ($urandom_range(0, 3))
                  0: cmd.month = 4'd1;
                  1: cmd.month = 4'd2;
                  2: cmd.month = 4'd12;
                  default: cmd.month = cdudc_pkg::MonthW'($urandom_range(1, 12));
               endcase
               cmd.day = cdudc_pkg::LdDayW'(EDGE_DAYS[$urandom_range(0, 4)]);
            end
         end else begin
            run_func = (sel < 70) ? cdudc_pkg::FUNC_FWD : cdudc_pkg::FUNC_BACK;
            run_left = $urandom_range(0, 40);
            cmd.func = run_func;
         end
      end
      return cmd;
   endfunction

   // Offers one command on the request stream and records its expected date once the
   // transfer happens. The sender works in bursts with random gaps in between.
   task automatic send_cmd(input cal_cmd_type cmd, input logic has_date,
                           input cal_date_type date);
      cal_date_type pred;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {cmd.year, cmd.month, cmd.day};
      req_tuser  <= cmd.func;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      advance_calendar(cmd, pred);
      date_q.push_back(has_date ? date : pred);
   endtask

   // Drops the request valid and waits until every expected response has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (date_q.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         n_errors++;
      end
   endtask

   initial begin : stimulus
      cal_cmd_type cmd;
      dir_row_type row;
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      n_errors      = 0;
      burst_left    = 0;
      run_left      = 0;
      run_func      = cdudc_pkg::FUNC_FWD;
      hold_requests = 0;
      cal_day   = 1;
      cal_month = 1;
      cal_year  = cdudc_pkg::DefaultYear;
      cal_leap  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         cmd = '{row.func, row.day, row.month, row.year};
         send_cmd(cmd, row.has_date, row.date);
      end
      wait_drained();

      for (i = 0; i < NUM_RANDOM; i++) begin
         // The receiver holds off for a long stretch while the sender keeps offering
         // commands back to back, so both stages fill and the request side stalls.
         if (i == HOLD_ITEM) begin
            hold_requests++;
            burst_left = 40;
         end
         if (i == NUM_RANDOM / 2) wait_drained();
         send_cmd(next_random_cmd(), 1'b0, NO_DATE);
      end
      wait_drained();
      repeat (10) @(posedge clock);

      if (n_errors == 0 && date_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // The receiver stalls on a pattern of its own: always ready, coin flips, a periodic
   // stall, or mostly stalled, each for a random stretch of cycles.
   initial begin : receiver
      int mode;
      int mode_left;
      int period;
      int phase;
      int hold_cnt;
      rsp_tready  = 1'b0;
      hold_served = 0;
      mode      = 0;
      mode_left = 0;
      period    = 3;
      phase     = 0;
      hold_cnt  = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served++;
            hold_cnt = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(30, 200);
            period    = $urandom_range(2, 5);
         end
         mode_left--;
         phase++;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (phase % period) != 0;
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Every response transfer is checked field by field against the oldest expected date.
   always @(posedge clock) begin : result_check
      cal_date_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (date_q.size() == 0) begin
            $display("%0t ns: response %h with no date expected", $time, rsp_tdata);
            n_errors++;
         end else begin
            want = date_q.pop_front();
            compare_field("cur_day", want.day, rsp_tdata[4:0]);
            compare_field("cur_month", want.month, rsp_tdata[8:5]);
            compare_field("cur_year", want.year, rsp_tdata[22:9]);
            compare_field("leap_flag", want.leap, rsp_tdata[23]);
            compare_field("year_fixed", want.year_fixed, rsp_tdata[24]);
            compare_field("month_fixed", want.month_fixed, rsp_tdata[25]);
            compare_field("day_fixed", want.day_fixed, rsp_tdata[26]);
            compare_field("padding", 0, rsp_tdata[31:27]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule

/* files.f */
hw/rtl/cdudc_pkg.sv
hw/rtl/calendar_date_up_down_counter.sv
hw/rtl/cdudc_checker.sv
test/tb_top.sv
